>>> rtl/assert_macros.svh
// Assertion macros shared by the window lattice RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop is a full property expression, clocked on clk and disabled during reset
`define WLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never hold
`define WLI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WLI_ASSERT(lbl, prop, msg)
`define WLI_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/wli_pkg.sv
// Shared types and constants for the window lattice intersect block
package wli_pkg;

    localparam int IN_W         = 32;   // region coordinates
    localparam int IDX_W        = 32;   // emitted window indices
    localparam int STEP_W       = 16;   // window size, stride, origin
    localparam int EXT_W        = 32;   // tensor extent
    localparam int CFG_W        = 32;   // config write data
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_W        = IN_W + 2;  // division numerators, signed
    localparam int AW           = 40;   // internal index and pixel arithmetic
    localparam int COORD_BITS   = 32;
    localparam int MAX_SPAN_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_ROWS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_COLS = 3'd7;

    typedef struct packed {
        logic signed [IN_W-1:0] row_start;
        logic signed [IN_W-1:0] row_stop;
        logic signed [IN_W-1:0] col_start;
        logic signed [IN_W-1:0] col_stop;
    } query_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] win_row;
        logic signed [IDX_W-1:0] win_col;
        logic                    found;
        logic                    overflow;
        logic                    last;
    } result_t;

    // axis unit status toward the sequencer
    typedef struct packed {
        logic done;   // one-cycle pulse, results below valid from then on
        logic ok;     // index range not empty
        logic cut;    // span was truncated to MAX_SPAN
    } axis_stat_t;

endpackage

>>> rtl/wli_div.sv
// Bit-serial floor divider: signed numerator by positive stride, one quotient bit per cycle
`include "assert_macros.svh"

module wli_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic signed [wli_pkg::NUM_W-1:0]  num,
    input  logic [wli_pkg::STEP_W-1:0]        den,
    output logic                              done,
    output logic signed [wli_pkg::NUM_W:0]    quo,
    output logic [wli_pkg::STEP_W-1:0]        rmd
);
    import wli_pkg::*;

    localparam int CNTW = $clog2(NUM_W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIX  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic                     neg_reg, neg_next;
    logic [STEP_W-1:0]        den_reg, den_next;
    logic [NUM_W-1:0]         sh_reg, sh_next;
    logic [STEP_W-1:0]        rem_reg, rem_next;
    logic signed [NUM_W:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]        rmd_reg, rmd_next;

    logic [STEP_W:0]          trial;
    logic                     fits;
    logic signed [NUM_W:0]    q0;

    assign trial = {rem_reg, sh_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign q0    = $signed({1'b0, sh_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        den_next   = den_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        rmd_next   = rmd_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (load)
                begin
                    neg_next   = num[NUM_W-1];
                    den_next   = den;
                    sh_next    = num[NUM_W-1] ? (~num + 1'b1) : num;  // magnitude
                    rem_next   = '0;
                    cnt_next   = CNTW'(NUM_W);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? STEP_W'(trial - {1'b0, den_reg}) : trial[STEP_W-1:0];
                sh_next  = {sh_reg[NUM_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = D_FIX;
                end
            end
            D_FIX:
            begin
                // turn truncating magnitude result into floor quotient, remainder in [0, den)
                if (!neg_reg)
                begin
                    quo_next = q0;
                    rmd_next = rem_reg;
                end
                else if (rem_reg == '0)
                begin
                    quo_next = -q0;
                    rmd_next = '0;
                end
                else
                begin
                    quo_next = ~q0;
                    rmd_next = den_reg - rem_reg;
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        rmd_reg <= rmd_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rmd  = rmd_reg;

    `WLI_ASSERT(a_div_den_nonzero, load && state_reg == D_IDLE |-> den != '0, "divider loaded with zero stride")
    `WLI_ASSERT(a_div_rem_range, done_reg |-> rmd_reg < den_reg, "floor remainder not below stride")
    `WLI_ASSERT(a_div_done_pulse, done_reg |=> !done_reg, "divider done held over two cycles")

endmodule

>>> rtl/wli_axis.sv
// One axis of the lattice: index range by floor/ceil division, span cut, extent mask scan
`include "assert_macros.svh"

module wli_axis #(
    parameter int MAX_SPAN = wli_pkg::MAX_SPAN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic signed [wli_pkg::IN_W-1:0]   start_px,
    input  logic signed [wli_pkg::IN_W-1:0]   stop_px,
    input  logic [wli_pkg::STEP_W-1:0]        win,
    input  logic [wli_pkg::STEP_W-1:0]        step,
    input  logic signed [wli_pkg::STEP_W-1:0] org,
    input  logic signed [wli_pkg::EXT_W-1:0]  ext,
    output wli_pkg::axis_stat_t               stat,
    output logic signed [wli_pkg::AW-1:0]     lo,
    output logic [MAX_SPAN-1:0]               mask
);
    import wli_pkg::*;

    localparam int KW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int CW = $clog2(MAX_SPAN + 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_SPAN = 2'd2;
    localparam logic [1:0] A_SCAN = 2'd3;

    logic signed [AW-1:0]    start_w, stop_w, org_w, win_w, step_w, ext_w;
    logic signed [AW-1:0]    n_lo, n_hi;
    logic signed [NUM_W-1:0] num_lo, num_hi;

    logic                    lo_done, hi_done;
    logic signed [NUM_W:0]   quo_lo, quo_hi;
    logic [STEP_W-1:0]       rmd_lo, rmd_hi;

    logic [1:0]              state_reg, state_next;
    logic                    done_reg, done_next;
    logic                    ok_reg, ok_next;
    logic                    cut_reg, cut_next;
    logic signed [AW-1:0]    n_lo_reg, n_lo_next;
    logic signed [AW-1:0]    lo_reg, lo_next;
    logic signed [AW-1:0]    hi_reg, hi_next;
    logic signed [AW-1:0]    base_reg, base_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [MAX_SPAN-1:0]     mask_reg, mask_next;

    logic                    rnz;
    logic signed [AW-1:0]    diff;
    logic                    fits_ext;

    assign start_w = AW'(start_px);
    assign stop_w  = AW'(stop_px);
    assign org_w   = AW'(org);
    assign win_w   = AW'(win);
    assign step_w  = AW'(step);
    assign ext_w   = AW'(ext);

    // lo = ceil((start - org - win + 1) / step), hi = floor((stop - 1 - org) / step)
    assign n_lo   = start_w - org_w - win_w + AW'(1);
    assign n_hi   = stop_w - AW'(1) - org_w;
    assign num_lo = NUM_W'(n_lo);
    assign num_hi = NUM_W'(n_hi);

    wli_div u_div_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (go),
        .num   (num_lo),
        .den   (step),
        .done  (lo_done),
        .quo   (quo_lo),
        .rmd   (rmd_lo)
    );

    wli_div u_div_hi (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (go),
        .num   (num_hi),
        .den   (step),
        .done  (hi_done),
        .quo   (quo_hi),
        .rmd   (rmd_hi)
    );

    assign rnz  = (rmd_lo != '0);
    assign diff = hi_reg - lo_reg;
    // window pixel base must sit in [0, ext - win]; negative extent never clips
    assign fits_ext = ext[EXT_W-1] || (!base_reg[AW-1] && ((base_reg + win_w) <= ext_w));

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        cut_next   = cut_reg;
        n_lo_next  = n_lo_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        mask_next  = mask_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (go)
                begin
                    n_lo_next  = n_lo;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                if (lo_done)
                begin
                    lo_next    = rnz ? (AW'(quo_lo) + AW'(1)) : AW'(quo_lo);
                    hi_next    = AW'(quo_hi);
                    // lo*step + org, taken from the floor remainder
                    base_next  = n_lo_reg + org_w - AW'(rmd_lo) + (rnz ? step_w : AW'(0));
                    state_next = A_SPAN;
                end
            end
            A_SPAN:
            begin
                ok_next   = !diff[AW-1];
                cut_next  = !diff[AW-1] && (diff >= AW'(MAX_SPAN));
                cnt_next  = (diff >= AW'(MAX_SPAN)) ? CW'(MAX_SPAN) : CW'(diff + AW'(1));
                k_next    = '0;
                mask_next = '0;
                if (diff[AW-1])
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                begin
                    state_next = A_SCAN;
                end
            end
            A_SCAN:
            begin
                mask_next = mask_reg | (MAX_SPAN'(fits_ext) << k_reg);
                base_next = base_reg + step_w;
                k_next    = KW'(k_reg + 1'b1);
                if ((CW'(k_reg) + CW'(1)) == cnt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            cut_reg   <= cut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_lo_reg <= n_lo_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        mask_reg <= mask_next;
    end

    assign stat.done = done_reg;
    assign stat.ok   = ok_reg;
    assign stat.cut  = cut_reg;
    assign lo        = lo_reg;
    assign mask      = mask_reg;

    `WLI_NEVER(a_axis_div_sync, lo_done != hi_done, "axis dividers finished apart")
    `WLI_NEVER(a_axis_hi_rmd, hi_done && rmd_hi >= step, "upper floor remainder not below stride")
    `WLI_ASSERT(a_axis_scan_range, state_reg == A_SCAN |-> CW'(k_reg) < cnt_reg, "mask scan past span")
    `WLI_ASSERT(a_axis_cnt_cap, state_reg == A_SCAN |-> cnt_reg <= CW'(MAX_SPAN) && cnt_reg != '0, "span count out of range")

endmodule

>>> rtl/window_lattice_intersect_top.sv
// Top level: config registers, query sequencer and window index emitter
//
// A query is taken when start is high and busy is low. Both axes run in parallel, each
// with two bit-serial floor dividers: after the accepting edge come the quotient-bit
// steps and a sign fix, then a capture, the span cut and an extent scan of one kept
// index per cycle (up to MAX_SPAN). The sequencer then sees both axes done and decides,
// so an empty answer leaves after the longer of the two scans. Emission walks the kept
// row/column grid, one emitted window, skipped position or dropped row per cycle; busy
// drops with the last beat. Each result beat is on result for exactly one cycle, flagged
// by strobe, and must be taken then: the receiver cannot stall.
// Config writes take effect at once and are meant for when busy is low.
`include "assert_macros.svh"

module window_lattice_intersect_top #(
    parameter int MAX_SPAN = wli_pkg::MAX_SPAN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  wli_pkg::query_t                 query,
    output logic                            strobe,
    output wli_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [wli_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wli_pkg::CFG_W-1:0]       cfg_data
);
    import wli_pkg::*;

    localparam int KW       = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int SAT_BITS = (COORD_BITS < IDX_W) ? COORD_BITS : IDX_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_WAIT = 2'd1;
    localparam logic [1:0] T_EVAL = 2'd2;
    localparam logic [1:0] T_EMIT = 2'd3;

    function automatic logic signed [IDX_W-1:0] sat_idx(input logic signed [AW-1:0] v);
        if (v > SAT_HI)
        begin
            return IDX_W'(SAT_HI);
        end
        if (v < SAT_LO)
        begin
            return IDX_W'(SAT_LO);
        end
        return IDX_W'(v);
    endfunction

    // configuration
    logic [STEP_W-1:0]        win_rows_reg, win_cols_reg, step_rows_reg, step_cols_reg;
    logic signed [STEP_W-1:0] origin_rows_reg, origin_cols_reg;
    logic signed [EXT_W-1:0]  extent_rows_reg, extent_cols_reg;
    logic [STEP_W-1:0]        step_rows_eff, step_cols_eff;

    // axis units
    logic                     go;
    axis_stat_t               rstat, cstat;
    logic signed [AW-1:0]     rlo, clo;
    logic [MAX_SPAN-1:0]      rmask, cmask;

    // sequencer
    logic [1:0]               state_reg, state_next;
    logic                     rdone_reg, rdone_next;
    logic                     cdone_reg, cdone_next;
    logic                     ovf_reg, ovf_next;
    logic [KW-1:0]            rk_reg, rk_next;
    logic [KW-1:0]            ck_reg, ck_next;
    logic                     strobe_reg, strobe_next;
    result_t                  result_reg, result_next;

    logic [MAX_SPAN-1:0]      row_bits, col_bits;
    logic                     row_on, row_more, col_on, col_more;
    logic signed [AW-1:0]     row_idx, col_idx;

    assign step_rows_eff = (step_rows_reg == '0) ? STEP_W'(1) : step_rows_reg;
    assign step_cols_eff = (step_cols_reg == '0) ? STEP_W'(1) : step_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_rows_reg    <= STEP_W'(64);
            win_cols_reg    <= STEP_W'(64);
            step_rows_reg   <= STEP_W'(64);
            step_cols_reg   <= STEP_W'(64);
            origin_rows_reg <= '0;
            origin_cols_reg <= '0;
            extent_rows_reg <= '1;
            extent_cols_reg <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIN_ROWS:    win_rows_reg    <= cfg_data[STEP_W-1:0];
                REG_WIN_COLS:    win_cols_reg    <= cfg_data[STEP_W-1:0];
                REG_STEP_ROWS:   step_rows_reg   <= cfg_data[STEP_W-1:0];
                REG_STEP_COLS:   step_cols_reg   <= cfg_data[STEP_W-1:0];
                REG_ORIGIN_ROWS: origin_rows_reg <= $signed(cfg_data[STEP_W-1:0]);
                REG_ORIGIN_COLS: origin_cols_reg <= $signed(cfg_data[STEP_W-1:0]);
                REG_EXTENT_ROWS: extent_rows_reg <= $signed(cfg_data[EXT_W-1:0]);
                REG_EXTENT_COLS: extent_cols_reg <= $signed(cfg_data[EXT_W-1:0]);
                default:         ;
            endcase
        end
    end

    assign go = start && (state_reg == T_IDLE);

    wli_axis #(
        .MAX_SPAN (MAX_SPAN)
    ) u_axis_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .start_px (query.row_start),
        .stop_px  (query.row_stop),
        .win      (win_rows_reg),
        .step     (step_rows_eff),
        .org      (origin_rows_reg),
        .ext      (extent_rows_reg),
        .stat     (rstat),
        .lo       (rlo),
        .mask     (rmask)
    );

    wli_axis #(
        .MAX_SPAN (MAX_SPAN)
    ) u_axis_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .start_px (query.col_start),
        .stop_px  (query.col_stop),
        .win      (win_cols_reg),
        .step     (step_cols_eff),
        .org      (origin_cols_reg),
        .ext      (extent_cols_reg),
        .stat     (cstat),
        .lo       (clo),
        .mask     (cmask)
    );

    // grid walk: rows slow, columns fast, jump past dead rows and row tails
    assign row_bits = rmask >> rk_reg;
    assign col_bits = cmask >> ck_reg;
    assign row_on   = row_bits[0];
    assign col_on   = col_bits[0];
    assign row_more = |(row_bits >> 1);
    assign col_more = |(col_bits >> 1);
    assign row_idx  = rlo + $signed(AW'(rk_reg));
    assign col_idx  = clo + $signed(AW'(ck_reg));

    always_comb
    begin
        state_next  = state_reg;
        rdone_next  = rdone_reg | rstat.done;
        cdone_next  = cdone_reg | cstat.done;
        ovf_next    = ovf_reg;
        rk_next     = rk_reg;
        ck_next     = ck_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            T_IDLE:
            begin
                rdone_next = 1'b0;
                cdone_next = 1'b0;
                if (go)
                begin
                    state_next = T_WAIT;
                end
            end
            T_WAIT:
            begin
                if (rdone_next && cdone_next)
                begin
                    state_next = T_EVAL;
                end
            end
            T_EVAL:
            begin
                ovf_next = rstat.cut | cstat.cut;
                rk_next  = '0;
                ck_next  = '0;
                if (!(rstat.ok && cstat.ok) || (rmask == '0) || (cmask == '0))
                begin
                    // empty answer; overflow only survives a non-empty lattice
                    strobe_next          = 1'b1;
                    result_next.win_row  = '0;
                    result_next.win_col  = '0;
                    result_next.found    = 1'b0;
                    result_next.overflow = rstat.ok && cstat.ok && (rstat.cut | cstat.cut);
                    result_next.last     = 1'b1;
                    state_next           = T_IDLE;
                end
                else
                begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (!row_on)
                begin
                    rk_next = KW'(rk_reg + 1'b1);
                    ck_next = '0;
                end
                else
                begin
                    if (col_on)
                    begin
                        strobe_next          = 1'b1;
                        result_next.win_row  = sat_idx(row_idx);
                        result_next.win_col  = sat_idx(col_idx);
                        result_next.found    = 1'b1;
                        result_next.overflow = ovf_reg;
                        result_next.last     = !col_more && !row_more;
                    end
                    if (!col_more)
                    begin
                        if (!row_more)
                        begin
                            state_next = T_IDLE;
                        end
                        else
                        begin
                            rk_next = KW'(rk_reg + 1'b1);
                            ck_next = '0;
                        end
                    end
                    else
                    begin
                        ck_next = KW'(ck_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            rdone_reg  <= 1'b0;
            cdone_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rdone_reg  <= rdone_next;
            cdone_reg  <= cdone_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg    <= ovf_next;
        rk_reg     <= rk_next;
        ck_reg     <= ck_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != T_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `WLI_ASSERT(a_top_last_ends, strobe_reg && result_reg.last |=> !strobe_reg, "beat right after last beat")
    `WLI_ASSERT(a_top_empty_last, strobe_reg && !result_reg.found |-> result_reg.last, "empty answer not marked last")
    `WLI_ASSERT(a_top_beat_src, strobe_reg |-> $past(state_reg) == T_EVAL || $past(state_reg) == T_EMIT, "beat outside emission")
    `WLI_NEVER(a_top_emit_masks, state_reg == T_EMIT && (rmask == '0 || cmask == '0), "emission with empty mask")

endmodule
